// ----- rtl/core/dmht_pkg.sv -----
// ============================================================================
// Direct-mapped hash table: shared package
// Types, command and response codes, slot states and hash helpers that the
// hash table modules share.
// ============================================================================
package dmht_pkg;

    localparam int HASH_W  = 32;
    localparam int SIZE_W  = 9;
    localparam int LEN_W   = 4;
    localparam int VALUE_W = 64;

    // Rotation grows by this many bits for each key byte, modulo 32.
    localparam logic [4:0] ROT_STEP = 5'd7;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_STATS  = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        RSP_INSERTED  = 3'd0,
        RSP_REFUSED   = 3'd1,
        RSP_FOUND     = 3'd2,
        RSP_NOT_FOUND = 3'd3,
        RSP_DELETED   = 3'd4,
        RSP_DEL_MISS  = 3'd5,
        RSP_DONE      = 3'd6
    } t_rsp_code;

    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_FILLED  = 2'd1,
        SLOT_DELETED = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_EXEC,
        S_CLEAR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] key_bytes;
        logic [3:0]  key_len;
        logic [63:0] entry_value;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] found_value;
        logic [7:0]  slot_index;
        logic [8:0]  used_count;
        logic [8:0]  deleted_count;
        logic [8:0]  empty_count;
    } t_rsp;

    // Sign-extend one key byte to the hash width.
    function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
        return {{(HASH_W-8){b[7]}}, b};
    endfunction

    // Rotate a 32-bit word left.
    function automatic logic [HASH_W-1:0] rotl32(input logic [HASH_W-1:0] v,
                                                 input logic [4:0] r);
        logic [2*HASH_W-1:0] d;
        d = {v, v} << r;
        return d[2*HASH_W-1:HASH_W];
    endfunction

endpackage

// ----- rtl/core/dmht_ram.sv -----
// ============================================================================
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read data holds until the
// next read.
// ============================================================================
module dmht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/dmht_hash.sv -----
// ============================================================================
// Key hash unit
// Byte-serial rotate-add hash: one key byte is folded into the sum per cycle.
// ============================================================================
module dmht_hash #(
    parameter int KEY_BYTES = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [KEY_BYTES*8-1:0]      i_key,
    input  logic [dmht_pkg::LEN_W-1:0]  i_len,
    output logic                        o_done,
    output logic [dmht_pkg::HASH_W-1:0] o_hash
);

    localparam int KW   = KEY_BYTES * 8;
    localparam int CNTW = $clog2(KEY_BYTES + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [KW-1:0]               r_key;
    logic [CNTW-1:0]             r_left;
    logic [4:0]                  r_rot;
    logic [dmht_pkg::HASH_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= (i_len != '0);
            r_done <= (i_len == '0);
        end else if (r_busy) begin
            if (r_left == CNTW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key  <= i_key;
            r_left <= CNTW'(i_len);
            r_rot  <= '0;
            r_sum  <= '0;
        end else if (r_busy) begin
            r_sum  <= r_sum + dmht_pkg::rotl32(dmht_pkg::sext8(r_key[7:0]), r_rot);
            r_key  <= r_key >> 8;
            r_rot  <= r_rot + dmht_pkg::ROT_STEP;
            r_left <= r_left - CNTW'(1);
        end
    end

    assign o_done = r_done;
    assign o_hash = r_sum;

endmodule

// ----- rtl/core/dmht_mod.sv -----
// ============================================================================
// Remainder unit
// Restoring division of the 32-bit hash by the table size, one quotient bit
// per cycle; only the remainder is kept.
// ============================================================================
module dmht_mod (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [dmht_pkg::HASH_W-1:0] i_dividend,
    input  logic [dmht_pkg::SIZE_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [dmht_pkg::SIZE_W-1:0] o_rem
);

    localparam int SW = dmht_pkg::SIZE_W;
    localparam int HW = dmht_pkg::HASH_W;
    localparam int CW = $clog2(HW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [HW-1:0] r_num;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_div;
    logic [SW:0]   trial;

    assign trial = {r_rem, r_num[HW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_cnt <= CW'(HW - 1);
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_cnt <= r_cnt - CW'(1);
            if (trial >= {1'b0, r_div}) begin
                r_rem <= SW'(trial - {1'b0, r_div});
            end else begin
                r_rem <= trial[SW-1:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/direct_mapped_hash_table_top.sv -----
// ============================================================================
// Direct-mapped hash table, top level
// Insert, delete and query on one hashed slot each, plus stats and clear.
// ============================================================================
// Insert, delete and query go from the accepted request through the
// byte-serial hash and the remainder unit, then a slot read-modify-write,
// to their response; stats answers directly, clear after sweeping all slots.
// Throughput: one request at a time; the next is taken once the previous
// response sits in the output register. Reset: synchronous, active low, then
// a pass over every entry clears the slot status memory before any request.
module direct_mapped_hash_table_top #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_BYTES   = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  dmht_pkg::t_req              i_in_req,
    // Response channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output dmht_pkg::t_rsp              o_out_rsp,
    // Table size register
    input  logic                        i_cfg_we,
    input  logic [dmht_pkg::SIZE_W-1:0] i_cfg_wdata
);

    localparam int AW       = $clog2(TABLE_DEPTH);
    localparam int CW       = $clog2(TABLE_DEPTH + 1);
    localparam int KW       = KEY_BYTES * 8;
    localparam int LW       = dmht_pkg::LEN_W;
    localparam int VW       = dmht_pkg::VALUE_W;
    localparam int SW       = dmht_pkg::SIZE_W;
    localparam int DW       = LW + KW + VW;
    localparam int SIZE_CAP = (TABLE_DEPTH > 511) ? 511 : TABLE_DEPTH;
    localparam int SUMW     = (CW + 1 > SW + 1) ? CW + 1 : SW + 1;

    // Control state.
    dmht_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic [CW-1:0]    r_used, n_used;
    logic [CW-1:0]    r_del, n_del;
    logic [SW-1:0]    r_size;
    logic             r_out_valid, n_out_valid;

    // Request and response payload.
    logic [2:0]       r_cmd, n_cmd;
    logic [KW-1:0]    r_key, n_key;
    logic [LW-1:0]    r_len, n_len;
    logic [VW-1:0]    r_value, n_value;
    logic [SW-1:0]    r_slot, n_slot;
    dmht_pkg::t_rsp   r_out, n_out;

    // Request decode.
    logic             in_acc;
    logic             out_free;
    logic [LW-1:0]    in_len;
    logic [KW-1:0]    in_key;
    logic [SW-1:0]    eff_size;

    // Hash and remainder units.
    logic                        hash_start;
    logic                        hash_done;
    logic [dmht_pkg::HASH_W-1:0] hash_val;
    logic                        mod_start;
    logic                        mod_done;
    logic [SW-1:0]               mod_rem;

    // Slot memories: status in one, key, length and value in the other.
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [1:0]    st_wdata;
    logic [1:0]    st_rdata;
    logic          dt_we;
    logic [DW-1:0] dt_wdata;
    logic [DW-1:0] dt_rdata;

    // Slot read-out and response build.
    logic [LW-1:0]   slot_len;
    logic [KW-1:0]   slot_key;
    logic [VW-1:0]   slot_val;
    logic            match;
    logic            load;
    logic [2:0]      rsp_code;
    logic [VW-1:0]   rsp_found;
    logic [SW-1:0]   rsp_slot;
    logic [SUMW-1:0] occ_sum;
    logic [SUMW-1:0] size_x;
    logic [SUMW-1:0] empty_x;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // A key longer than the stored width saturates, and bytes beyond the key
    // length are dropped so that stored keys compare as whole words.
    always_comb begin
        in_len = (i_in_req.key_len > LW'(KEY_BYTES)) ? LW'(KEY_BYTES) : i_in_req.key_len;
        for (int b = 0; b < KEY_BYTES; b++) begin
            in_key[b*8 +: 8] = (LW'(b) < in_len) ? i_in_req.key_bytes[b*8 +: 8] : 8'd0;
        end
    end

    // A size of zero behaves as one slot; a size beyond the memory is capped.
    always_comb begin
        if (r_size == '0) begin
            eff_size = SW'(1);
        end else if (int'(r_size) > SIZE_CAP) begin
            eff_size = SW'(SIZE_CAP);
        end else begin
            eff_size = r_size;
        end
    end

    dmht_hash #(
        .KEY_BYTES (KEY_BYTES)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (in_key),
        .i_len   (in_len),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    dmht_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (hash_val),
        .i_divisor  (eff_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    dmht_ram #(
        .WIDTH (2),
        .DEPTH (TABLE_DEPTH)
    ) u_status_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (st_rdata)
    );

    dmht_ram #(
        .WIDTH (DW),
        .DEPTH (TABLE_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (dt_we),
        .i_waddr (AW'(r_slot)),
        .i_wdata (dt_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (dt_rdata)
    );

    // The data word is {length, key, value}. Its contents only matter when
    // the status says the slot is not empty, and such a slot was written.
    assign slot_len  = dt_rdata[DW-1 -: LW];
    assign slot_key  = dt_rdata[VW +: KW];
    assign slot_val  = dt_rdata[VW-1:0];
    assign match     = (st_rdata != dmht_pkg::SLOT_EMPTY) && (slot_len == r_len) &&
                       (slot_key == r_key);
    assign dt_wdata  = {r_len, r_key, r_value};
    assign mem_raddr = AW'(mod_rem);

    // Next state and control. The sequencer walks a request through hash,
    // remainder, slot read and a single update step that waits for a free
    // output register; clear sweeps the status memory one entry per cycle.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_used      = r_used;
        n_del       = r_del;
        n_cmd       = r_cmd;
        n_key       = r_key;
        n_len       = r_len;
        n_value     = r_value;
        n_slot      = r_slot;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = (r_state == dmht_pkg::S_IDLE);
        hash_start  = 1'b0;
        mod_start   = 1'b0;
        mem_re      = 1'b0;
        st_we       = 1'b0;
        st_waddr    = AW'(r_slot);
        st_wdata    = dmht_pkg::SLOT_EMPTY;
        dt_we       = 1'b0;
        load        = 1'b0;
        rsp_code    = dmht_pkg::RSP_DONE;
        rsp_found   = '0;
        rsp_slot    = '0;

        case (r_state)
            dmht_pkg::S_INIT: begin
                st_we      = 1'b1;
                st_waddr   = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_clr_addr = '0;
                    n_state    = dmht_pkg::S_IDLE;
                end
            end
            dmht_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd   = i_in_req.cmd;
                    n_key   = in_key;
                    n_len   = in_len;
                    n_value = i_in_req.entry_value;
                    n_slot  = '0;
                    if (i_in_req.cmd inside {dmht_pkg::CMD_INSERT, dmht_pkg::CMD_DELETE,
                                             dmht_pkg::CMD_QUERY}) begin
                        hash_start = 1'b1;
                        n_state    = dmht_pkg::S_HASH;
                    end else if (i_in_req.cmd == dmht_pkg::CMD_CLEAR) begin
                        n_clr_addr = '0;
                        n_state    = dmht_pkg::S_CLEAR;
                    end else begin
                        n_state = dmht_pkg::S_FINISH;
                    end
                end
            end
            dmht_pkg::S_HASH: begin
                if (hash_done) begin
                    mod_start = 1'b1;
                    n_state   = dmht_pkg::S_MOD;
                end
            end
            dmht_pkg::S_MOD: begin
                if (mod_done) begin
                    mem_re  = 1'b1;
                    n_slot  = mod_rem;
                    n_state = dmht_pkg::S_EXEC;
                end
            end
            dmht_pkg::S_EXEC: begin
                if (out_free) begin
                    load     = 1'b1;
                    rsp_slot = r_slot;
                    n_state  = dmht_pkg::S_IDLE;
                    case (r_cmd)
                        dmht_pkg::CMD_INSERT: begin
                            if ((st_rdata == dmht_pkg::SLOT_FILLED) && !match) begin
                                rsp_code = dmht_pkg::RSP_REFUSED;
                            end else begin
                                rsp_code = dmht_pkg::RSP_INSERTED;
                                st_we    = 1'b1;
                                st_wdata = dmht_pkg::SLOT_FILLED;
                                dt_we    = 1'b1;
                                if (st_rdata == dmht_pkg::SLOT_EMPTY) begin
                                    n_used = r_used + CW'(1);
                                end else if (st_rdata == dmht_pkg::SLOT_DELETED) begin
                                    n_used = r_used + CW'(1);
                                    n_del  = r_del - CW'(1);
                                end
                            end
                        end
                        dmht_pkg::CMD_DELETE: begin
                            if (match) begin
                                rsp_code = dmht_pkg::RSP_DELETED;
                                if (st_rdata == dmht_pkg::SLOT_FILLED) begin
                                    st_we    = 1'b1;
                                    st_wdata = dmht_pkg::SLOT_DELETED;
                                    n_used   = r_used - CW'(1);
                                    n_del    = r_del + CW'(1);
                                end
                            end else begin
                                rsp_code = dmht_pkg::RSP_DEL_MISS;
                            end
                        end
                        dmht_pkg::CMD_QUERY: begin
                            if (match && (st_rdata == dmht_pkg::SLOT_FILLED)) begin
                                rsp_code  = dmht_pkg::RSP_FOUND;
                                rsp_found = slot_val;
                            end else begin
                                rsp_code = dmht_pkg::RSP_NOT_FOUND;
                            end
                        end
                        default: begin
                            rsp_code = dmht_pkg::RSP_DONE;
                        end
                    endcase
                end
            end
            dmht_pkg::S_CLEAR: begin
                st_we      = 1'b1;
                st_waddr   = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(TABLE_DEPTH - 1)) begin
                    n_clr_addr = '0;
                    n_used     = '0;
                    n_del      = '0;
                    n_state    = dmht_pkg::S_FINISH;
                end
            end
            dmht_pkg::S_FINISH: begin
                if (out_free) begin
                    load    = 1'b1;
                    n_state = dmht_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dmht_pkg::S_IDLE;
            end
        endcase

        // Counts in the response are those after the request took effect.
        // The free slot count is floored at zero, which matters when the size
        // was lowered without a clear.
        occ_sum = SUMW'(n_used) + SUMW'(n_del);
        size_x  = SUMW'(eff_size);
        empty_x = (occ_sum >= size_x) ? '0 : size_x - occ_sum;

        if (load) begin
            n_out_valid         = 1'b1;
            n_out.status        = rsp_code;
            n_out.found_value   = rsp_found;
            n_out.slot_index    = 8'(rsp_slot);
            n_out.used_count    = 9'(n_used);
            n_out.deleted_count = 9'(n_del);
            n_out.empty_count   = 9'(empty_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmht_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_used      <= '0;
            r_del       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_addr  <= n_clr_addr;
            r_used      <= n_used;
            r_del       <= n_del;
            r_out_valid <= n_out_valid;
        end
    end

    // Write table size register only with no request in flight; not enforced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 9'd256;
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_len   <= n_len;
        r_value <= n_value;
        r_slot  <= n_slot;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

endmodule

// ----- verif/tb_direct_mapped_hash_table_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Direct-mapped hash table testbench
// Drives insert, delete, query, stats and clear requests into the hash table
// and checks every response against a predictor of the slot memory. The
// predictor keeps its own slot states, keys, values, counters and table size.
// Both handshakes idle and stall at random. The table size is changed between
// phases, sometimes without a following clear.
// ============================================================================
module tb_direct_mapped_hash_table_top;

    import dmht_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int KEY_BYTES   = 8;

    // Command codes 5 to 7 are not defined. The block must answer them with a
    // plain done response.
    localparam logic [2:0] CMD_RESERVED_LO = 3'd5;
    localparam logic [2:0] CMD_RESERVED_HI = 3'd7;

    localparam int ITEMS_PER_PHASE = 150;
    localparam int PHASE_COUNT     = 10;
    // In this phase the sender stops halfway and waits for every response.
    localparam int PAUSE_PHASE     = 4;
    // After this many responses the receiver refuses responses for a long
    // stretch, so the block backs up and stops taking requests.
    localparam int HOLD_AFTER      = 600;
    localparam int HOLD_CYCLES     = 400;
    // A clear walks all slots, so the settle time at the end covers that.
    localparam int SETTLE_CYCLES   = TABLE_DEPTH + 40;
    // The timeout covers the slowest correct run: every request a clear,
    // with the longest sender gap and the longest receiver stall each time.
    localparam int TIMEOUT_NS      = 4_000_000;

    // ------------------------------------------------------------------------
    // Predictor and checker of the responses
    // ------------------------------------------------------------------------
    class hash_table_scoreboard #(int DEPTH = 256, int MAX_KEY = 8);
        t_slot_st          slot_state [DEPTH];
        logic [63:0]       slot_key   [DEPTH];
        logic [3:0]        slot_len   [DEPTH];
        logic [63:0]       slot_value [DEPTH];
        int unsigned       used_total;
        int unsigned       deleted_total;
        logic [SIZE_W-1:0] table_size;
        t_rsp              expected_rsp_q [$];
        int unsigned       error_count;
        int unsigned       response_count;

        function new();
            foreach (slot_state[i]) begin
                slot_state[i] = SLOT_EMPTY;
                slot_key[i]   = '0;
                slot_len[i]   = '0;
                slot_value[i] = '0;
            end
            used_total     = 0;
            deleted_total  = 0;
            table_size     = 9'd256;
            error_count    = 0;
            response_count = 0;
        endfunction

        // Keeps the bytes that belong to a key of the given length.
        static function logic [63:0] byte_mask(int unsigned len);
            if (len >= 8) begin
                return '1;
            end
            return (64'd1 << (len * 8)) - 64'd1;
        endfunction

        // Sum of the sign-extended key bytes, byte i rotated left by 7*i mod 32.
        function logic [31:0] rotate_add_hash(logic [63:0] key, int unsigned len);
            logic [31:0] sum;
            logic [31:0] word;
            logic [7:0]  b;
            int unsigned sh;
            sum = '0;
            for (int i = 0; i < len; i++) begin
                b    = key[i*8 +: 8];
                word = {{24{b[7]}}, b};
                sh   = (i * ROT_STEP) % 32;
                if (sh != 0) begin
                    word = (word << sh) | (word >> (32 - sh));
                end
                sum = sum + word;
            end
            return sum;
        endfunction

        function int unsigned pending();
            return expected_rsp_q.size();
        endfunction

        function void set_table_size(logic [SIZE_W-1:0] v);
            table_size = v;
        endfunction

        // Applies one accepted request to the model and queues its response.
        function void note_request(t_req req);
            int unsigned len;
            int unsigned size;
            int unsigned slot;
            int unsigned empty;
            logic [63:0] key;
            t_slot_st    st;
            logic        hit;
            t_rsp        want;
            len = (req.key_len > MAX_KEY) ? MAX_KEY : req.key_len;
            key = req.key_bytes & byte_mask(len);
            if (table_size == 0) begin
                size = 1;
            end else if (table_size > DEPTH) begin
                size = DEPTH;
            end else begin
                size = table_size;
            end
            slot        = 0;
            st          = SLOT_EMPTY;
            hit         = 1'b0;
            want        = '0;
            want.status = RSP_DONE;

            if (req.cmd <= CMD_QUERY) begin
                slot = rotate_add_hash(key, len) % size;
                st   = slot_state[slot];
                hit  = (st != SLOT_EMPTY) && (slot_len[slot] == len) && (slot_key[slot] == key);
            end

            case (req.cmd)
                CMD_INSERT: begin
                    if (st == SLOT_FILLED && !hit) begin
                        want.status = RSP_REFUSED;
                    end else begin
                        if (st == SLOT_EMPTY) begin
                            used_total++;
                        end else if (st == SLOT_DELETED) begin
                            used_total++;
                            deleted_total--;
                        end
                        slot_state[slot] = SLOT_FILLED;
                        slot_key[slot]   = key;
                        slot_len[slot]   = 4'(len);
                        slot_value[slot] = req.entry_value;
                        want.status      = RSP_INSERTED;
                    end
                end
                CMD_DELETE: begin
                    if (hit) begin
                        // A slot that is already deleted stays so, still a hit.
                        if (st == SLOT_FILLED) begin
                            used_total--;
                            deleted_total++;
                            slot_state[slot] = SLOT_DELETED;
                        end
                        want.status = RSP_DELETED;
                    end else begin
                        want.status = RSP_DEL_MISS;
                    end
                end
                CMD_QUERY: begin
                    if (hit && st == SLOT_FILLED) begin
                        want.status      = RSP_FOUND;
                        want.found_value = slot_value[slot];
                    end else begin
                        want.status = RSP_NOT_FOUND;
                    end
                end
                CMD_CLEAR: begin
                    foreach (slot_state[i]) begin
                        slot_state[i] = SLOT_EMPTY;
                    end
                    used_total    = 0;
                    deleted_total = 0;
                end
                default: begin
                end
            endcase

            empty = (used_total + deleted_total >= size) ? 0 : size - used_total - deleted_total;
            want.slot_index    = 8'(slot);
            want.used_count    = 9'(used_total);
            want.deleted_count = 9'(deleted_total);
            want.empty_count   = 9'(empty);
            expected_rsp_q.push_back(want);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("response %0d: %s is 0x%0h, expected 0x%0h",
                     response_count, what, got, want);
            error_count++;
        endtask

        task check_response(t_rsp got);
            t_rsp want;
            response_count++;
            if (expected_rsp_q.size() == 0) begin
                report_mismatch("status of a response with no request open", got.status, '0);
            end else begin
                want = expected_rsp_q.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.found_value !== want.found_value)
                    report_mismatch("found_value", got.found_value, want.found_value);
                if (got.slot_index !== want.slot_index)
                    report_mismatch("slot_index", got.slot_index, want.slot_index);
                if (got.used_count !== want.used_count)
                    report_mismatch("used_count", got.used_count, want.used_count);
                if (got.deleted_count !== want.deleted_count)
                    report_mismatch("deleted_count", got.deleted_count, want.deleted_count);
                if (got.empty_count !== want.empty_count)
                    report_mismatch("empty_count", got.empty_count, want.empty_count);
            end
        endtask
    endclass

    typedef hash_table_scoreboard #(TABLE_DEPTH, KEY_BYTES) t_scoreboard;

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_req              i_in_req    = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_rsp              o_out_rsp;
    logic              i_cfg_we    = 1'b0;
    logic [SIZE_W-1:0] i_cfg_wdata = '0;

    t_scoreboard sb = new();

    // Keys in use during one phase. Most requests pick from this small set so
    // that inserts, deletes and queries keep landing on the same slots.
    logic [63:0] key_pool [$];
    logic [3:0]  len_pool [$];

    direct_mapped_hash_table_top #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BYTES   (KEY_BYTES)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_rsp   (o_out_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog. Only a hung block or a lost response should ever get here.
    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Responses are sampled at the rising edge, where the handshake happens.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_response(o_out_rsp);
        end
    end

    // ------------------------------------------------------------------------
    // Helpers for the stimulus
    // ------------------------------------------------------------------------

    // Length of an idle stretch: mostly a few cycles, now and then a long one.
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    // Offers one request and holds it until the block takes it. Valid is left
    // high afterwards so that a back-to-back request needs no second write to
    // it in the same time step.
    task automatic send_request(input t_req req);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_req   <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input logic [63:0] key,
                            input logic [3:0] len, input logic [63:0] value);
        t_req req;
        req.cmd         = cmd;
        req.key_bytes   = key;
        req.key_len     = len;
        req.entry_value = value;
        send_request(req);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // Stops offering requests until every response has come back. Every
    // request gives exactly one response, so the block is idle afterwards.
    task automatic wait_for_responses();
        pause_sender(1);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_table_size(input logic [SIZE_W-1:0] size);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        sb.set_table_size(size);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // A random request. Most keys come from the phase's key set, some with
    // junk above their length or a length above eight; the rest are random.
    function automatic t_req random_request();
        t_req        req;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            req.cmd = CMD_INSERT;
        end else if (roll < 55) begin
            req.cmd = CMD_DELETE;
        end else if (roll < 85) begin
            req.cmd = CMD_QUERY;
        end else if (roll < 93) begin
            req.cmd = CMD_STATS;
        end else if (roll < 95) begin
            req.cmd = CMD_CLEAR;
        end else begin
            req.cmd = 3'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
        end

        if (key_pool.size() == 0 || $urandom_range(0, 9) == 0) begin
            req.key_bytes = {$urandom, $urandom};
            req.key_len   = 4'($urandom_range(0, 15));
        end else begin
            pick          = $urandom_range(0, key_pool.size() - 1);
            req.key_bytes = key_pool[pick];
            req.key_len   = len_pool[pick];
            if ($urandom_range(0, 2) == 0) begin
                req.key_bytes |= {$urandom, $urandom} & ~sb.byte_mask(req.key_len);
            end
            if (req.key_len == 4'd8 && $urandom_range(0, 2) == 0) begin
                req.key_len = 4'($urandom_range(9, 15));
            end
        end

        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            req.entry_value = '0;
        end else if (roll == 1) begin
            req.entry_value = '1;
        end else begin
            req.entry_value = {$urandom, $urandom};
        end
        return req;
    endfunction

    // ------------------------------------------------------------------------
    // Receiver: random stalls, stretches with none, and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall_left;
        int unsigned mode_left;
        bit          steady;
        bit          held_off;
        stall_left = 0;
        mode_left  = 0;
        steady     = 1'b0;
        held_off   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && sb.response_count >= HOLD_AFTER) begin
                // The sender keeps offering requests meanwhile, so the block
                // ends up holding a response and refusing new requests.
                held_off = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (mode_left == 0) begin
                    steady    = ($urandom_range(0, 3) == 0);
                    mode_left = 128;
                end
                mode_left--;
                if (stall_left != 0) begin
                    stall_left--;
                    i_out_ready <= 1'b0;
                end else if (!steady && $urandom_range(0, 3) == 0) begin
                    stall_left = idle_length() - 1;
                    i_out_ready <= 1'b0;
                end else begin
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender: reset, directed requests, random phases, end of run
    // ------------------------------------------------------------------------
    initial begin
        t_req        req;
        int unsigned issued;
        int unsigned pool_size;
        int unsigned len;
        bit          steady_phase;
        logic [SIZE_W-1:0] size;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // The block clears its slot states after reset and only then raises
        // ready, so nothing is offered before that.
        do @(posedge i_clk); while (!o_in_ready);

        // Directed requests at the reset table size of 256. An empty table
        // first, then the empty key, keys of all ones (every byte negative),
        // a single byte with only the sign bit set, a length above eight that
        // must saturate onto an existing key, and zero bytes inside a key.
        send_cmd(CMD_STATS,  64'h0, 4'd0, 64'h0);
        send_cmd(CMD_QUERY,  64'h41, 4'd1, 64'h0);
        send_cmd(CMD_DELETE, 64'h41, 4'd1, 64'h0);
        send_cmd(CMD_INSERT, 64'hDEAD_BEEF_0BAD_F00D, 4'd0, '1);
        send_cmd(CMD_QUERY,  64'h0, 4'd0, 64'h0);
        send_cmd(CMD_INSERT, '1, 4'd8, 64'h0);
        send_cmd(CMD_INSERT, 64'h80, 4'd1, 64'h8000_0000_0000_0001);
        send_cmd(CMD_INSERT, '1, 4'd15, 64'h0123_4567_89AB_CDEF);
        send_cmd(CMD_QUERY,  '1, 4'd12, 64'h0);
        send_cmd(CMD_INSERT, 64'h0000_0000_0000_4100, 4'd3, 64'h5A5A_A5A5_5A5A_A5A5);
        send_cmd(CMD_QUERY,  64'h0000_0000_0000_4100, 4'd2, 64'h0);
        wait_for_responses();

        // A single slot: every key collides. Covers a refused insert, a delete
        // miss, deleting twice, a query on a deleted slot and an insert that
        // reuses a deleted slot. Then the undefined command codes.
        write_table_size(9'd1);
        send_cmd(CMD_CLEAR,  64'h0, 4'd0, 64'h0);
        send_cmd(CMD_INSERT, 64'h41, 4'd1, 64'h1111_2222_3333_4444);
        send_cmd(CMD_INSERT, 64'h42, 4'd1, 64'h5555_6666_7777_8888);
        send_cmd(CMD_QUERY,  64'h42, 4'd1, 64'h0);
        send_cmd(CMD_DELETE, 64'h42, 4'd1, 64'h0);
        send_cmd(CMD_DELETE, 64'h41, 4'd1, 64'h0);
        send_cmd(CMD_DELETE, 64'h41, 4'd1, 64'h0);
        send_cmd(CMD_QUERY,  64'h41, 4'd1, 64'h0);
        send_cmd(CMD_INSERT, 64'h42, 4'd1, 64'h5555_6666_7777_8888);
        send_cmd(CMD_STATS,  64'h0, 4'd0, 64'h0);
        for (int c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++) begin
            send_cmd(3'(c), {$urandom, $urandom}, 4'd4, 64'h0);
        end

        // Random phases. Each one starts idle with a new table size, which
        // includes zero, the largest value of the register and values above
        // the depth. Usually a clear follows; otherwise the old contents and
        // counts stay, so the empty count may reach zero.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            wait_for_responses();
            case (phase)
                0:       size = 9'd511;
                1:       size = 9'd0;
                2:       size = 9'd256;
                3:       size = 9'd2;
                4:       size = 9'd7;
                5:       size = 9'd255;
                6:       size = 9'd1;
                7:       size = 9'd300;
                8:       size = 9'd16;
                default: size = 9'($urandom_range(1, TABLE_DEPTH));
            endcase
            write_table_size(size);
            if ($urandom_range(0, 3) != 0) begin
                send_cmd(CMD_CLEAR, {$urandom, $urandom}, 4'($urandom_range(0, 15)), 64'h0);
            end

            key_pool.delete();
            len_pool.delete();
            pool_size = $urandom_range(4, 40);
            repeat (pool_size) begin
                len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, KEY_BYTES);
                key_pool.push_back({$urandom, $urandom} & sb.byte_mask(len));
                len_pool.push_back(4'(len));
            end

            // One phase in four runs the sender without any gaps.
            steady_phase = (phase % 4 == 2);
            issued       = 0;
            while (issued < ITEMS_PER_PHASE) begin
                req = random_request();
                send_request(req);
                // Undefined commands do nothing, so they do not count.
                if (req.cmd <= CMD_CLEAR) begin
                    issued++;
                end
                if (!steady_phase && $urandom_range(0, 99) >= 55) begin
                    pause_sender(idle_length());
                end
                if (phase == PAUSE_PHASE && issued == ITEMS_PER_PHASE / 2) begin
                    wait_for_responses();
                end
            end
        end

        // Drain, then give a late or extra response time to show up.
        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/dmht_pkg.sv
rtl/core/dmht_ram.sv
rtl/core/dmht_hash.sv
rtl/core/dmht_mod.sv
rtl/core/direct_mapped_hash_table_top.sv
verif/tb_direct_mapped_hash_table_top.sv
